>>> design/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and field widths for the subtree cover revocation tree.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int OP_W    = 2;
  localparam int ID_W    = 64;
  localparam int TIME_W  = 32;
  localparam int KIND_W  = 3;
  localparam int NODE_W  = 7;
  localparam int MATCH_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ASSIGN = 2'd0,
    OP_REVOKE = 2'd1,
    OP_COVER  = 2'd2
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ASSIGNED    = 3'd0,
    KIND_FULL        = 3'd1,
    KIND_REVOKE_DONE = 3'd2,
    KIND_COVER_NODE  = 3'd3,
    KIND_COVER_EMPTY = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ASSIGN,
    ST_REVOKE,
    ST_COVER,
    ST_PUSH
  } state_t;

endpackage

>>> design/sct_if.sv
// ----------------------------------------------------------------------------
// sct_in_if / sct_out_if
// Valid/ready channels carrying command beats in and result beats out.
// ----------------------------------------------------------------------------
interface sct_in_if;
  logic                          valid;
  logic                          ready;
  logic [sct_pkg::OP_W-1:0]      op;
  logic [sct_pkg::ID_W-1:0]      id;
  logic [sct_pkg::TIME_W-1:0]    time_value;

  modport source (output valid, op, id, time_value, input ready);
  modport sink   (input valid, op, id, time_value, output ready);
endinterface

interface sct_out_if;
  logic                          valid;
  logic                          ready;
  logic [sct_pkg::KIND_W-1:0]    kind;
  logic [sct_pkg::NODE_W-1:0]    node_index;
  logic [sct_pkg::MATCH_W-1:0]   matched;
  logic                          last;

  modport source (output valid, kind, node_index, matched, last, input ready);
  modport sink   (input valid, kind, node_index, matched, last, output ready);
endinterface

>>> design/subtree_cover_revocation_tree.sv
// ----------------------------------------------------------------------------
// subtree_cover_revocation_tree
// Complete binary revocation tree with leaf assignment, revocation and
// complete-subtree cover listing.
// ----------------------------------------------------------------------------
// One command beat is handled at a time; the next is taken once the final
// result of the current one has been moved into the output register. Leaf ids
// and times live in one synchronous memory with a registered read port; a
// flop per leaf tracks occupancy and revocation marks, so no clearing pass is
// needed after reset. Assign walks the occupancy bits one leaf per cycle. Revoke
// reads one leaf per cycle from the memory. Cover checks one sibling pair per
// cycle while the output side does not stall.
// ----------------------------------------------------------------------------
module subtree_cover_revocation_tree #(
  parameter int LEAF_COUNT = 64,
  parameter int ID_WIDTH   = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  sct_in_if.sink    in_ch,
  sct_out_if.source out_ch
);

  localparam int LW  = $clog2(LEAF_COUNT);
  localparam int CW  = LW + 1;
  localparam int NW  = LW + 1;
  localparam int TW  = sct_pkg::TIME_W;
  localparam int MW  = ID_WIDTH + TW;

  sct_pkg::state_t state_r, state_nxt;

  sct_pkg::op_t      op_r;
  logic [ID_WIDTH-1:0] id_r;
  logic [TW-1:0]       tv_r;

  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [LW-1:0]  m_r, m_nxt;
  logic           cmp_v_r, cmp_v_nxt;
  logic [LW-1:0]  cmp_k_r;
  logic [CW-1:0]  count_r, count_nxt;
  logic           pend_v_r, pend_v_nxt;
  logic [NW-1:0]  pend_node_r, pend_node_nxt;

  logic [LEAF_COUNT-1:0] nz_r, nz_nxt;
  logic [LEAF_COUNT-1:0] marks_r, marks_nxt;

  sct_pkg::kind_t              res_kind_r, res_kind_nxt;
  logic [sct_pkg::NODE_W-1:0]  res_node_r, res_node_nxt;
  logic [sct_pkg::MATCH_W-1:0] res_matched_r, res_matched_nxt;

  logic                        out_valid_r, out_valid_nxt;
  sct_pkg::kind_t              out_kind_r, out_kind_nxt;
  logic [sct_pkg::NODE_W-1:0]  out_node_r, out_node_nxt;
  logic [sct_pkg::MATCH_W-1:0] out_matched_r, out_matched_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [MW-1:0] mem [LEAF_COUNT];
  logic [MW-1:0] mem_q_r;
  logic          mem_we;
  logic [LW-1:0] rd_addr;
  logic [LW-1:0] cnt_idx;

  logic [2*LEAF_COUNT-1:1] hit_w;

  logic in_fire, out_free;
  logic asg_free, asg_end;
  logic rev_done, rev_match;
  logic cov_root, cov_last, cov_stall, emit_c, par_hit, fin_v;
  logic [NW-1:0] left_n, right_n, node_c, fin_node;

  // revoked-subtree flags over the heap
  for (genvar k = 0; k < LEAF_COUNT; k++) begin : g_leaf
    assign hit_w[LEAF_COUNT + k] = marks_r[k];
  end
  for (genvar n = 1; n < LEAF_COUNT; n++) begin : g_node
    assign hit_w[n] = hit_w[2*n] | hit_w[2*n+1];
  end

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign cnt_idx  = cnt_r[LW-1:0];
  assign rd_addr  = cnt_idx;

  assign asg_end  = (cnt_r == CW'(LEAF_COUNT));
  assign asg_free = !asg_end && !nz_r[cnt_idx];

  assign rev_match = cmp_v_r && nz_r[cmp_k_r] && !marks_r[cmp_k_r]
                  && (mem_q_r[MW-1:TW] == id_r) && (mem_q_r[TW-1:0] < tv_r);
  assign rev_done  = asg_end && !cmp_v_r;

  assign left_n    = {m_r, 1'b0};
  assign right_n   = {m_r, 1'b1};
  assign par_hit   = hit_w[{1'b0, m_r}];
  assign emit_c    = par_hit && (!hit_w[left_n] || !hit_w[right_n]);
  assign node_c    = !hit_w[left_n] ? left_n : right_n;
  assign cov_root  = !hit_w[1];
  assign cov_last  = (m_r == LW'(LEAF_COUNT - 1));
  assign cov_stall = emit_c && pend_v_r && !out_free;
  assign fin_v     = emit_c || pend_v_r;
  assign fin_node  = emit_c ? node_c : pend_node_r;

  assign in_ch.ready       = (state_r == sct_pkg::ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.node_index = out_node_r;
  assign out_ch.matched    = out_matched_r;
  assign out_ch.last       = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sct_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (sct_pkg::op_t'(in_ch.op))
            sct_pkg::OP_ASSIGN: state_nxt = sct_pkg::ST_ASSIGN;
            sct_pkg::OP_REVOKE: state_nxt = sct_pkg::ST_REVOKE;
            sct_pkg::OP_COVER:  state_nxt = sct_pkg::ST_COVER;
            default:            state_nxt = sct_pkg::ST_IDLE;
          endcase
        end
      end
      sct_pkg::ST_ASSIGN: begin
        if (asg_end || asg_free) state_nxt = sct_pkg::ST_PUSH;
      end
      sct_pkg::ST_REVOKE: begin
        if (rev_done) state_nxt = sct_pkg::ST_PUSH;
      end
      sct_pkg::ST_COVER: begin
        if (cov_root || (!cov_stall && cov_last)) state_nxt = sct_pkg::ST_PUSH;
      end
      sct_pkg::ST_PUSH: begin
        if (out_free) state_nxt = sct_pkg::ST_IDLE;
      end
      default: state_nxt = sct_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt         = cnt_r;
    m_nxt           = m_r;
    cmp_v_nxt       = 1'b0;
    count_nxt       = count_r;
    pend_v_nxt      = pend_v_r;
    pend_node_nxt   = pend_node_r;
    nz_nxt          = nz_r;
    marks_nxt       = marks_r;
    res_kind_nxt    = res_kind_r;
    res_node_nxt    = res_node_r;
    res_matched_nxt = res_matched_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_kind_nxt    = out_kind_r;
    out_node_nxt    = out_node_r;
    out_matched_nxt = out_matched_r;
    out_last_nxt    = out_last_r;
    mem_we          = 1'b0;

    unique case (state_r)
      sct_pkg::ST_IDLE: begin
        cnt_nxt    = '0;
        m_nxt      = LW'(1);
        count_nxt  = '0;
        pend_v_nxt = 1'b0;
      end
      sct_pkg::ST_ASSIGN: begin
        res_matched_nxt = '0;
        if (asg_end) begin
          res_kind_nxt = sct_pkg::KIND_FULL;
          res_node_nxt = '0;
        end else if (asg_free) begin
          mem_we          = 1'b1;
          nz_nxt[cnt_idx] = (id_r != '0);
          res_kind_nxt    = sct_pkg::KIND_ASSIGNED;
          res_node_nxt    = sct_pkg::NODE_W'({1'b1, cnt_idx});
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      sct_pkg::ST_REVOKE: begin
        if (!asg_end) begin
          cnt_nxt   = cnt_r + CW'(1);
          cmp_v_nxt = 1'b1;
        end
        if (rev_match) begin
          marks_nxt[cmp_k_r] = 1'b1;
          count_nxt          = count_r + CW'(1);
        end
        res_kind_nxt    = sct_pkg::KIND_REVOKE_DONE;
        res_node_nxt    = '0;
        res_matched_nxt = sct_pkg::MATCH_W'(count_r);
      end
      sct_pkg::ST_COVER: begin
        res_matched_nxt = '0;
        if (cov_root) begin
          res_kind_nxt = sct_pkg::KIND_COVER_NODE;
          res_node_nxt = sct_pkg::NODE_W'(1);
        end else if (!cov_stall) begin
          if (emit_c) begin
            if (pend_v_r) begin
              out_valid_nxt   = 1'b1;
              out_kind_nxt    = sct_pkg::KIND_COVER_NODE;
              out_node_nxt    = sct_pkg::NODE_W'(pend_node_r);
              out_matched_nxt = '0;
              out_last_nxt    = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_node_nxt = node_c;
          end
          m_nxt = m_r + LW'(1);
          if (cov_last) begin
            marks_nxt    = '0;
            res_kind_nxt = fin_v ? sct_pkg::KIND_COVER_NODE : sct_pkg::KIND_COVER_EMPTY;
            res_node_nxt = fin_v ? sct_pkg::NODE_W'(fin_node) : '0;
          end
        end
      end
      sct_pkg::ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = res_kind_r;
          out_node_nxt    = res_node_r;
          out_matched_nxt = res_matched_r;
          out_last_nxt    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sct_pkg::ST_IDLE;
      cnt_r       <= '0;
      m_r         <= LW'(1);
      cmp_v_r     <= 1'b0;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      nz_r        <= '0;
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      m_r         <= m_nxt;
      cmp_v_r     <= cmp_v_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      nz_r        <= nz_nxt;
      marks_r     <= marks_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= sct_pkg::op_t'(in_ch.op);
      id_r <= in_ch.id[ID_WIDTH-1:0];
      tv_r <= in_ch.time_value;
    end
    cmp_k_r       <= cnt_idx;
    pend_node_r   <= pend_node_nxt;
    res_kind_r    <= res_kind_nxt;
    res_node_r    <= res_node_nxt;
    res_matched_r <= res_matched_nxt;
    out_kind_r    <= out_kind_nxt;
    out_node_r    <= out_node_nxt;
    out_matched_r <= out_matched_nxt;
    out_last_r    <= out_last_nxt;
  end

  // leaf id/time store
  always_ff @(posedge clk) begin
    if (mem_we && (op_r == sct_pkg::OP_ASSIGN)) begin
      mem[cnt_idx] <= {id_r, tv_r};
    end
    mem_q_r <= mem[rd_addr];
  end

endmodule

>>> tb/sv/tb_subtree_cover_revocation_tree.sv
// ----------------------------------------------------------------------------
// tb_subtree_cover_revocation_tree
// Self-checking bench for the subtree cover revocation tree. Command beats
// go in over a valid/ready channel with random gaps. A bench-side copy of the
// leaf ids, times and marks predicts every result beat. A separate process
// takes result beats with random stalls and compares them field by field, in
// order. Stimulus runs as directed corner cases, then weighted random traffic
// built around ids already in the tree, then a full tree and full revocation.
// ----------------------------------------------------------------------------
module tb_subtree_cover_revocation_tree;
  import sct_pkg::*;

  localparam int LEAVES = 64;
  localparam int NODES  = 2 * LEAVES;
  localparam logic [OP_W-1:0]   OP_UNDEF = 2'd3;
  localparam logic [ID_W-1:0]   ID_ONES  = '1;
  localparam logic [TIME_W-1:0] T_MAX    = '1;

  typedef struct packed {
    kind_t              kind;
    logic [NODE_W-1:0]  node;
    logic [MATCH_W-1:0] matched;
    logic               last;
  } beat_t;

  logic clk;
  logic rst_n;

  sct_in_if  in_ch ();
  sct_out_if out_ch ();

  subtree_cover_revocation_tree #(
    .LEAF_COUNT(LEAVES),
    .ID_WIDTH  (ID_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  logic [ID_W-1:0]   slot_id   [LEAVES];
  logic [TIME_W-1:0] slot_time [LEAVES];
  bit                slot_rev  [LEAVES];
  logic [ID_W-1:0]   id_pool   [6];
  beat_t             owed_beats[$];
  int                fail_count = 0;
  bit                in_idle    = 1'b1;
  bit                out_idle   = 1'b1;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void owe(kind_t kind, int node, int matched, bit last);
    beat_t b;
    b.kind    = kind;
    b.node    = NODE_W'(node);
    b.matched = MATCH_W'(matched);
    b.last    = last;
    owed_beats = {owed_beats, b};
  endfunction

  // Applies one accepted command to the bench copy of the tree and queues the
  // result beats it must produce.
  function automatic void tree_update(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                      logic [TIME_W-1:0] tv);
    bit    hit [NODES];
    int    free_leaf;
    int    cnt;
    int    emitted;
    beat_t tail;
    case (op)
      OP_ASSIGN: begin
        free_leaf = -1;
        for (int k = 0; k < LEAVES; k++)
          if (free_leaf < 0 && slot_id[k] == '0) free_leaf = k;
        if (free_leaf >= 0) begin
          slot_id[free_leaf]   = id;
          slot_time[free_leaf] = tv;
          owe(KIND_ASSIGNED, LEAVES + free_leaf, 0, 1'b1);
        end else begin
          owe(KIND_FULL, 0, 0, 1'b1);
        end
      end
      OP_REVOKE: begin
        cnt = 0;
        for (int k = 0; k < LEAVES; k++) begin
          if (slot_id[k] != '0 && slot_id[k] == id && slot_time[k] < tv && !slot_rev[k]) begin
            slot_rev[k] = 1'b1;
            cnt++;
          end
        end
        owe(KIND_REVOKE_DONE, 0, cnt, 1'b1);
      end
      OP_COVER: begin
        hit[0] = 1'b0;
        for (int k = 0; k < LEAVES; k++) hit[LEAVES + k] = slot_rev[k];
        for (int n = LEAVES - 1; n >= 1; n--) hit[n] = hit[2 * n] | hit[2 * n + 1];
        emitted = 0;
        if (!hit[1]) begin
          owe(KIND_COVER_NODE, 1, 0, 1'b0);
          emitted = 1;
        end else begin
          for (int n = 2; n < NODES; n++) begin
            if (!hit[n] && hit[n / 2]) begin
              owe(KIND_COVER_NODE, n, 0, 1'b0);
              emitted++;
            end
          end
        end
        for (int k = 0; k < LEAVES; k++) slot_rev[k] = 1'b0;
        if (emitted == 0) begin
          owe(KIND_COVER_EMPTY, 0, 0, 1'b1);
        end else begin
          tail = owed_beats.pop_back();
          tail.last = 1'b1;
          owed_beats = {owed_beats, tail};
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [TIME_W-1:0] tv);
    int gap;
    gap = in_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.id         <= id;
    in_ch.time_value <= tv;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tree_update(op, id, tv);
  endtask

  // Drops valid and waits until every owed result beat has been seen.
  task automatic settle;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (owed_beats.size() != 0);
  endtask

  function automatic void cmp_field(string what, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
    end
  endfunction

  initial begin : result_check
    int    stall;
    beat_t want;
    forever begin
      stall = out_idle ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n === 1'b1 && out_ch.valid === 1'b1));
      if (owed_beats.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat, expected none, got kind=%0d node=%0d matched=%0d last=%0d",
                 $time, out_ch.kind, out_ch.node_index, out_ch.matched, out_ch.last);
      end else begin
        want = owed_beats.pop_front();
        cmp_field("kind", 8'(want.kind), 8'(out_ch.kind));
        cmp_field("node_index", 8'(want.node), 8'(out_ch.node_index));
        cmp_field("matched", 8'(want.matched), 8'(out_ch.matched));
        cmp_field("last", 8'(want.last), 8'(out_ch.last));
      end
    end
  end

  task automatic test_directed_cases;
    in_idle  = 1'b1;
    out_idle = 1'b1;
    send_cmd(OP_COVER, '0, '0);                    // nothing marked: root only
    send_cmd(OP_REVOKE, '0, T_MAX);                // zero id matches nothing
    send_cmd(OP_ASSIGN, '0, T_MAX);                // zero id: leaf stays empty
    send_cmd(OP_ASSIGN, ID_ONES, '0);              // reuses the same leaf
    send_cmd(OP_ASSIGN, 64'd1, T_MAX - 1);
    send_cmd(OP_ASSIGN, ID_ONES, 32'd5);
    send_cmd(OP_REVOKE, ID_ONES, '0);              // strict cutoff
    send_cmd(OP_REVOKE, ID_ONES, 32'd1);
    send_cmd(OP_REVOKE, ID_ONES, T_MAX);           // already marked not counted
    send_cmd(OP_REVOKE, 64'd1, T_MAX - 1);         // equal time not revoked
    send_cmd(OP_UNDEF, ID_ONES, T_MAX);
    send_cmd(OP_COVER, '0, '0);
    send_cmd(OP_COVER, ID_ONES, T_MAX);            // marks were cleared
    send_cmd(OP_REVOKE, 64'd1, T_MAX);
    send_cmd(OP_ASSIGN, 64'h8000_0000_0000_0000, 32'h8000_0000);
    send_cmd(OP_REVOKE, 64'h8000_0000_0000_0000, T_MAX);
    send_cmd(OP_COVER, '0, '0);
    send_cmd(OP_UNDEF, '0, '0);
    send_cmd(OP_REVOKE, 64'd2, T_MAX);
    send_cmd(OP_COVER, '0, '0);
    settle();
  endtask

  task automatic test_random_traffic(int items);
    int                pick;
    int                r;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tv;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) begin
        r = $urandom_range(0, 3);
        in_idle  = r[0];
        out_idle = r[1];
      end
      pick = $urandom_range(0, 99);
      r    = $urandom_range(0, 9);
      if (pick < 30) begin
        op = OP_ASSIGN;
        if (r < 6)       id = id_pool[r];
        else if (r < 8)  id = {$urandom, $urandom};
        else if (r == 8) id = '0;
        else             id = ID_ONES;
        tv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, T_MAX - 1) : $urandom_range(0, 200);
      end else if (pick < 75) begin
        op = OP_REVOKE;
        if (r < 7)      id = slot_id[$urandom_range(0, LEAVES - 1)];
        else if (r < 9) id = id_pool[$urandom_range(0, 5)];
        else            id = {$urandom, $urandom};
        r  = $urandom_range(0, 9);
        if (r < 7)       tv = $urandom_range(0, 260);
        else if (r < 9)  tv = T_MAX;
        else             tv = $urandom;
      end else if (pick < 95) begin
        op = OP_COVER;
        id = {$urandom, $urandom};
        tv = $urandom;
      end else begin
        op = OP_UNDEF;
        id = {$urandom, $urandom};
        tv = $urandom;
      end
      send_cmd(op, id, tv);
    end
    settle();
  endtask

  task automatic test_full_tree_empty_cover;
    int              empties;
    bit              listed [logic [ID_W-1:0]];
    logic [ID_W-1:0] uniq[$];
    in_idle  = 1'b1;
    out_idle = 1'b1;
    empties  = 0;
    for (int k = 0; k < LEAVES; k++) if (slot_id[k] == '0) empties++;
    for (int i = 0; i < empties; i++)
      send_cmd(OP_ASSIGN, id_pool[$urandom_range(0, 5)], $urandom_range(0, T_MAX - 1));
    send_cmd(OP_ASSIGN, '0, T_MAX);                // tree full
    send_cmd(OP_ASSIGN, ID_ONES, '0);
    for (int k = 0; k < LEAVES; k++) begin
      if (!listed.exists(slot_id[k])) begin
        listed[slot_id[k]] = 1'b1;
        uniq = {uniq, slot_id[k]};
      end
    end
    foreach (uniq[i]) send_cmd(OP_REVOKE, uniq[i], T_MAX);
    send_cmd(OP_COVER, '0, '0);                    // every leaf revoked
    send_cmd(OP_COVER, '0, '0);
    send_cmd(OP_REVOKE, uniq[0], T_MAX);
    send_cmd(OP_COVER, '0, '0);
    settle();
  endtask

  initial begin : stimulus
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_ASSIGN;
    in_ch.id         <= '0;
    in_ch.time_value <= '0;
    rst_n            <= 1'b0;
    for (int k = 0; k < LEAVES; k++) begin
      slot_id[k]   = '0;
      slot_time[k] = '0;
      slot_rev[k]  = 1'b0;
    end
    foreach (id_pool[i]) begin
      id_pool[i] = {$urandom, $urandom};
      if (id_pool[i] == '0) id_pool[i] = 64'd1;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_traffic(400);
    test_full_tree_empty_cover();
    repeat (200) @(posedge clk);
    if (owed_beats.size() != 0) begin
      fail_count++;
      $display("%0t: results missing, expected 0 outstanding, got %0d",
               $time, owed_beats.size());
    end
    if (fail_count == 0) begin
      $display("PASS subtree_cover_revocation_tree");
    end else begin
      $display("FAIL subtree_cover_revocation_tree");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("FAIL subtree_cover_revocation_tree");
    $finish;
  end

endmodule

>>> subtree_cover_revocation_tree.f
design/sct_pkg.sv
design/sct_if.sv
design/subtree_cover_revocation_tree.sv
tb/sv/tb_subtree_cover_revocation_tree.sv
